/* hdl/buffer_pool_page_replacement_macros.svh */
// assertion macros for the buffer pool page replacement block
// used by the top level only; needs clk and rst_n in scope
`ifndef BUFFER_POOL_PAGE_REPLACEMENT_MACROS_SVH
`define BUFFER_POOL_PAGE_REPLACEMENT_MACROS_SVH

// property checked on every clock edge outside reset
`define BPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked on the next clock edge
`define BPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/bpr_pkg.sv */
// shared types and codes for the buffer pool page replacement block
// used by bpr_cell and the top level
package bpr_pkg;

    localparam int IW = 6;  // frame index width for up to 64 frames

    localparam logic [1:0] CMD_ACCESS = 2'd0;
    localparam logic [1:0] CMD_PIN    = 2'd1;
    localparam logic [1:0] CMD_UNPIN  = 2'd2;

    localparam logic [1:0] POL_CLOCK = 2'd0;
    localparam logic [1:0] POL_LRU   = 2'd1;
    localparam logic [1:0] POL_MRU   = 2'd2;

    localparam logic [7:0] PIN_MAX = 8'd255;

    // search wavefront handed from cell to cell
    typedef struct packed {
        logic          match_f;
        logic [IW-1:0] match_i;
        logic          free_f;
        logic [IW-1:0] free_i;
        logic          best_f;
        logic [IW-1:0] best_i;
        logic [31:0]   best_stamp;
        logic          hi0_f;
        logic [IW-1:0] hi0_i;
        logic          lo0_f;
        logic [IW-1:0] lo0_i;
        logic          hic_f;
        logic [IW-1:0] hic_i;
        logic          loc_f;
        logic [IW-1:0] loc_i;
    } wave_t;

    // key and update broadcast to every cell
    typedef struct packed {
        logic [7:0]    tid;
        logic [15:0]   pg;
        logic [IW-1:0] ptr;
        logic          mru;
        logic [31:0]   stamp;
        logic          hit_en;
        logic          load_en;
        logic          pin_en;
        logic          unpin_en;
        logic [IW-1:0] tgt;
        logic          clr_en;
        logic          clr_all;
        logic [IW-1:0] vic;
    } upd_t;

endpackage

/* hdl/buffer_pool_page_replacement.sv */
// an accepted item enters the sweep state while the search wave crosses the cell
// chain, then the decide state, where the result is committed to the output register;
// in_stall is held until commit, and the decide state waits while a pending result is
// stalled; the next item is taken while a finished result waits in the output register
// reset: all frames invalid and unpinned, counters and clock hand zero,
// policy clock, frames_in_use 10
module buffer_pool_page_replacement
    import bpr_pkg::*;
#(
    parameter int FRAMES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  table_id,
    input  logic [15:0] page_num,
    input  logic [3:0]  unpin_frame,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic        loaded,
    output logic [3:0]  frame_index,
    output logic        replaced,
    output logic        no_victim,
    output logic [31:0] disk_reads
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam logic [IW-1:0]    LAST   = IW'(FRAMES - 1);
    localparam logic [CNT_W-1:0] CNT_FR = CNT_W'(FRAMES);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SWEEP  = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       cmd_reg;
    logic [7:0]       tid_reg;
    logic [15:0]      pg_reg;
    logic [3:0]       uf_reg;
    logic [1:0]       policy_reg;
    logic [4:0]       fiu_reg;
    logic [31:0]      stamp_reg;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] vcount_reg, vcount_next;
    logic [31:0]      reads_reg, reads_next;

    logic        ov_reg;
    logic        hit_reg, loaded_reg, repl_reg, nov_reg;
    logic [3:0]  fidx_reg;

    logic        in_acc, go;
    upd_t        upd;
    wave_t       waves [0:FRAMES];
    wave_t       res;
    logic [6:0]  lim;
    logic        d_hit, d_load, d_repl, d_nov;
    logic [IW-1:0] d_idx;
    logic        is_access;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign go       = (state_reg == S_DECIDE) && !(ov_reg && out_stall);
    assign is_access = (cmd_reg == CMD_ACCESS) || (cmd_reg == CMD_PIN);

    // cell chain
    assign waves[0] = '0;
    genvar g;
    generate
        for (g = 0; g < FRAMES; g++)
        begin : g_cell
            bpr_cell #(.IDX(g)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .upd      (upd),
                .wave_in  (waves[g]),
                .wave_out (waves[g+1])
            );
        end
    endgenerate
    assign res = waves[FRAMES];

    always_comb
    begin
        if (fiu_reg == 5'd0)
        begin
            lim = 7'd1;
        end
        else if (7'(fiu_reg) > 7'(FRAMES))
        begin
            lim = 7'(FRAMES);
        end
        else
        begin
            lim = 7'(fiu_reg);
        end
    end

    always_comb
    begin
        upd          = '0;
        upd.tid      = tid_reg;
        upd.pg       = pg_reg;
        upd.ptr      = IW'(ptr_reg);
        upd.mru      = (policy_reg == POL_MRU);
        upd.stamp    = stamp_reg;
        d_hit        = 1'b0;
        d_load       = 1'b0;
        d_repl       = 1'b0;
        d_nov        = 1'b0;
        d_idx        = '0;
        ptr_next     = ptr_reg;
        vcount_next  = vcount_reg;
        reads_next   = reads_reg;
        if (cmd_reg == CMD_UNPIN)
        begin
            d_idx        = IW'(uf_reg);
            upd.tgt      = IW'(uf_reg);
            upd.unpin_en = go && (7'(uf_reg) < 7'(FRAMES));
        end
        else if (is_access)
        begin
            upd.pin_en = (cmd_reg == CMD_PIN);
            if (res.match_f)
            begin
                d_hit      = 1'b1;
                d_idx      = res.match_i;
            end
            else if (7'(vcount_reg) < lim && res.free_f)
            begin
                d_load      = 1'b1;
                d_idx       = res.free_i;
                vcount_next = vcount_reg + 1'b1;
            end
            else if (policy_reg == POL_LRU || policy_reg == POL_MRU)
            begin
                if (res.best_f)
                begin
                    d_load = 1'b1;
                    d_repl = 1'b1;
                    d_idx  = res.best_i;
                end
                else
                begin
                    d_nov = 1'b1;
                end
            end
            else
            begin
                // clock: first unreferenced candidate from the hand, else first candidate
                d_load = 1'b1;
                d_repl = 1'b1;
                if (res.hi0_f)
                begin
                    d_idx = res.hi0_i;
                end
                else if (res.lo0_f)
                begin
                    d_idx = res.lo0_i;
                end
                else if (res.hic_f)
                begin
                    d_idx       = res.hic_i;
                    upd.clr_all = 1'b1;
                end
                else if (res.loc_f)
                begin
                    d_idx       = res.loc_i;
                    upd.clr_all = 1'b1;
                end
                else
                begin
                    d_load = 1'b0;
                    d_repl = 1'b0;
                    d_nov  = 1'b1;
                end
                upd.clr_en = go && !d_nov;
                upd.vic    = d_idx;
                if (!d_nov)
                begin
                    ptr_next = (d_idx == LAST) ? '0 : IDX_W'(d_idx + 1'b1);
                end
            end
            if (d_load)
            begin
                reads_next = reads_reg + 32'd1;
            end
            if (d_nov)
            begin
                d_idx = '0;
            end
            upd.tgt     = d_idx;
            upd.hit_en  = go && d_hit;
            upd.load_en = go && d_load;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_SWEEP;
                    cnt_next   = '0;
                end
            end
            S_SWEEP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_FR - 1'b1)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            policy_reg <= POL_CLOCK;
            fiu_reg    <= 5'd10;
            stamp_reg  <= 32'd0;
            ptr_reg    <= '0;
            vcount_reg <= '0;
            reads_reg  <= 32'd0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en)
            begin
                if (cfg_index == 1'b0)
                begin
                    policy_reg <= cfg_data[1:0];
                end
                else
                begin
                    fiu_reg <= cfg_data;
                end
            end
            if (go)
            begin
                ptr_reg    <= ptr_next;
                vcount_reg <= vcount_next;
                reads_reg  <= reads_next;
                if (is_access)
                begin
                    stamp_reg <= stamp_reg + 32'd1;
                end
                ov_reg <= 1'b1;
            end
            else if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg <= cmd;
            tid_reg <= table_id;
            pg_reg  <= page_num;
            uf_reg  <= unpin_frame;
        end
        if (go)
        begin
            hit_reg    <= d_hit;
            loaded_reg <= d_load;
            repl_reg   <= d_repl;
            nov_reg    <= d_nov;
            fidx_reg   <= 4'(d_idx);
        end
    end

    assign out_valid   = ov_reg;
    assign hit         = hit_reg;
    assign loaded      = loaded_reg;
    assign replaced    = repl_reg;
    assign no_victim   = nov_reg;
    assign frame_index = fidx_reg;
    assign disk_reads  = reads_reg;

`include "buffer_pool_page_replacement_macros.svh"

    `BPR_ASSERT(a_hit_not_loaded, !(ov_reg && hit_reg && loaded_reg), "hit and load together")
    `BPR_ASSERT(a_vcount_range, vcount_reg <= CNT_FR, "valid count above frame count")
    `BPR_ASSERT_NEXT(a_accept_sweep, in_acc, state_reg == S_SWEEP, "item accepted without sweep")
    `BPR_ASSERT(a_nov_clean, !(ov_reg && nov_reg && (loaded_reg || repl_reg)), "failed miss loaded")

endmodule

/* hdl/bpr_cell.sv */
// one frame of the page table: holds key, pin count, reference bit, stamp
// depends on bpr_pkg; passes the search wavefront to the next cell
module bpr_cell
    import bpr_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  upd_t  upd,
    input  wave_t wave_in,
    output wave_t wave_out
);

    localparam logic [IW-1:0] MY = IW'(IDX);

    logic        valid_reg;
    logic [7:0]  pin_reg;
    logic        ref_reg;
    logic [7:0]  table_reg;
    logic [15:0] page_reg;
    logic [31:0] stamp_reg;
    wave_t       wave_reg;
    wave_t       wave_next;

    logic cand;
    logic ref0;
    logic hi;
    logic in_rng;
    logic is_tgt;
    logic better;

    assign cand   = valid_reg && (pin_reg == 8'd0);
    assign ref0   = cand && !ref_reg;
    assign hi     = (MY >= upd.ptr);
    assign is_tgt = (MY == upd.tgt);
    assign in_rng = (upd.ptr <= upd.vic) ? (hi && (MY < upd.vic)) : (hi || (MY < upd.vic));
    assign better = upd.mru ? (stamp_reg > wave_in.best_stamp)
                            : (stamp_reg < wave_in.best_stamp);

    always_comb
    begin
        wave_next = wave_in;
        if (!wave_in.match_f && valid_reg && table_reg == upd.tid && page_reg == upd.pg)
        begin
            wave_next.match_f = 1'b1;
            wave_next.match_i = MY;
        end
        if (!wave_in.free_f && !valid_reg)
        begin
            wave_next.free_f = 1'b1;
            wave_next.free_i = MY;
        end
        if (cand && (!wave_in.best_f || better))
        begin
            wave_next.best_f     = 1'b1;
            wave_next.best_i     = MY;
            wave_next.best_stamp = stamp_reg;
        end
        if (ref0 && hi && !wave_in.hi0_f)
        begin
            wave_next.hi0_f = 1'b1;
            wave_next.hi0_i = MY;
        end
        if (ref0 && !wave_in.lo0_f)
        begin
            wave_next.lo0_f = 1'b1;
            wave_next.lo0_i = MY;
        end
        if (cand && hi && !wave_in.hic_f)
        begin
            wave_next.hic_f = 1'b1;
            wave_next.hic_i = MY;
        end
        if (cand && !wave_in.loc_f)
        begin
            wave_next.loc_f = 1'b1;
            wave_next.loc_i = MY;
        end
    end

    assign wave_out = wave_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg  <= '0;
            valid_reg <= 1'b0;
            pin_reg   <= 8'd0;
            ref_reg   <= 1'b0;
        end
        else
        begin
            wave_reg <= wave_next;
            // clock hand sweep clears reference bits it passes
            if (upd.clr_en && cand && (upd.clr_all || in_rng))
            begin
                ref_reg <= 1'b0;
            end
            if (is_tgt && upd.hit_en)
            begin
                ref_reg <= 1'b1;
                if (upd.pin_en && pin_reg != PIN_MAX)
                begin
                    pin_reg <= pin_reg + 8'd1;
                end
            end
            if (is_tgt && upd.load_en)
            begin
                valid_reg <= 1'b1;
                ref_reg   <= 1'b1;
                pin_reg   <= upd.pin_en ? 8'd1 : 8'd0;
            end
            if (is_tgt && upd.unpin_en && valid_reg && pin_reg != 8'd0)
            begin
                pin_reg <= pin_reg - 8'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_tgt && (upd.hit_en || upd.load_en))
        begin
            stamp_reg <= upd.stamp;
        end
        if (is_tgt && upd.load_en)
        begin
            table_reg <= upd.tid;
            page_reg  <= upd.pg;
        end
    end

endmodule
